[hw/rtl/tts_pkg.sv]
package tts_pkg;

    localparam int THREAD_SLOTS = 16;
    localparam int SLOT_W = 4;

    typedef enum logic [1:0] {
        ACT_REGISTER = 2'd0,
        ACT_SLEEP    = 2'd1,
        ACT_EXIT     = 2'd2,
        ACT_YIELD    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_READY = 2'd1,
        ST_SLEEP = 2'd2,
        ST_EXIT  = 2'd3
    } slot_status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_SCAN = 1'b1
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        name_key;
        logic signed [31:0] now_ms;
        logic [30:0]        sleep_ms;
    } tts_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] running_thread;
        logic [SLOT_W-1:0] previous_thread;
        logic [SLOT_W-1:0] registered_slot;
        logic              table_full;
    } tts_out_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              wr_sleep;
        logic              wr_exit;
        logic [SLOT_W-1:0] cur;
        logic [31:0]       deadline;
        logic              is_reg;
        logic [31:0]       key;
        logic signed [31:0] now;
    } tts_ctrl_t;

    typedef struct packed {
        logic stop;
        logic take;
    } tts_hit_t;

endpackage

[hw/rtl/tts_cell.sv]
module tts_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [tts_pkg::SLOT_W-1:0] idx,
    input  tts_pkg::tts_ctrl_t         ctrl,
    input  logic                      tok_in,
    output logic                      tok_out,
    output tts_pkg::tts_hit_t          hit
);
    import tts_pkg::*;

    slot_status_t status_reg, status_next;
    logic [31:0]  key_reg, key_next;
    logic [31:0]  deadline_reg, deadline_next;
    logic         tok_reg, tok_next;
    logic         is_cur;
    logic         expired;

    assign is_cur  = (ctrl.cur == idx);
    assign expired = ($signed(deadline_reg) < $signed(ctrl.now));

    always_comb
    begin
        status_next   = status_reg;
        key_next      = key_reg;
        deadline_next = deadline_reg;
        hit           = '0;
        if (ctrl.wr_sleep && is_cur && status_reg != ST_EMPTY)
        begin
            status_next   = ST_SLEEP;
            deadline_next = ctrl.deadline;
        end
        else if (ctrl.wr_exit && is_cur)
        begin
            status_next = ST_EXIT;
        end
        else if (tok_in)
        begin
            if (ctrl.is_reg)
            begin
                if (status_reg == ST_EMPTY || key_reg == ctrl.key)
                begin
                    hit.stop    = 1'b1;
                    hit.take    = 1'b1;
                    key_next    = ctrl.key;
                    status_next = ST_READY;
                end
            end
            else
            begin
                priority if (status_reg == ST_EMPTY)
                begin
                    hit.stop = 1'b1;
                end
                else if (status_reg == ST_READY)
                begin
                    hit.stop = 1'b1;
                    hit.take = 1'b1;
                end
                else if (status_reg == ST_SLEEP && expired)
                begin
                    hit.stop    = 1'b1;
                    hit.take    = 1'b1;
                    status_next = ST_READY;
                end
            end
        end
        tok_next = tok_in && !hit.stop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_EMPTY;
            tok_reg    <= 1'b0;
        end
        else
        begin
            status_reg <= status_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        deadline_reg <= deadline_next;
    end

    assign tok_out = tok_reg;

endmodule

[hw/rtl/thread_table_scheduler.sv]
// Thread table scheduler: a row of slot cells scanned by a travelling token.
// An accepted start launches a token at slot 1 that moves upward one slot per cycle
// until a slot cell stops it; a scan that runs off the end is the longest. The
// result strobe follows the scan, and busy drops in the strobe cycle.
// Flow: start is taken only while idle, so one beat is in flight at a time; the receiver cannot stall.
// Reset: all slots empty, idle thread running, no scan in flight.
module thread_table_scheduler (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tts_pkg::tts_in_t  item,
    output logic              done,
    output tts_pkg::tts_out_t result
);
    import tts_pkg::*;

    fsm_state_t        state_reg, state_next;
    logic              accept;
    logic              tok_start_reg, tok_start_next;
    logic              done_reg, done_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic              is_reg_reg;
    logic [31:0]       key_reg;
    logic signed [31:0] now_reg;
    tts_out_t          result_reg, result_next;
    tts_ctrl_t         ctrl;
    logic              tok [THREAD_SLOTS:1];
    tts_hit_t          hits [THREAD_SLOTS-1:1];
    logic              stop_any;
    logic [SLOT_W-1:0] take_idx;
    logic              take_any;
    logic              finish;

    assign accept = start && (state_reg == FSM_IDLE);

    assign ctrl.wr_sleep = accept && (action_t'(item.action) == ACT_SLEEP) && (cur_reg != '0);
    assign ctrl.wr_exit  = accept && (action_t'(item.action) == ACT_EXIT) && (cur_reg != '0);
    assign ctrl.cur      = cur_reg;
    assign ctrl.deadline = item.now_ms + {1'b0, item.sleep_ms};
    assign ctrl.is_reg   = is_reg_reg;
    assign ctrl.key      = key_reg;
    assign ctrl.now      = now_reg;

    assign tok[1] = tok_start_reg;

    genvar gi;
    generate
        for (gi = 1; gi < THREAD_SLOTS; gi++)
        begin : g_cell
            tts_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (SLOT_W'(gi)),
                .ctrl    (ctrl),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1]),
                .hit     (hits[gi])
            );
        end
    endgenerate

    always_comb
    begin
        stop_any = 1'b0;
        take_any = 1'b0;
        take_idx = '0;
        for (int i = 1; i < THREAD_SLOTS; i++)
        begin
            stop_any = stop_any | hits[i].stop;
            take_any = take_any | hits[i].take;
            take_idx = take_idx | (hits[i].take ? SLOT_W'(i) : '0);
        end
    end

    assign finish = (state_reg == FSM_SCAN) && (stop_any || tok[THREAD_SLOTS]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: if (start) state_next = FSM_SCAN;
            FSM_SCAN: if (finish) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        tok_start_next = 1'b0;
        done_next      = 1'b0;
        cur_next       = cur_reg;
        result_next    = result_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                tok_start_next = start;
            end
            FSM_SCAN:
            begin
                if (finish)
                begin
                    done_next                   = 1'b1;
                    result_next.previous_thread = cur_reg;
                    if (is_reg_reg)
                    begin
                        result_next.running_thread  = cur_reg;
                        result_next.registered_slot = take_any ? take_idx : '0;
                        result_next.table_full      = !take_any;
                    end
                    else
                    begin
                        cur_next                    = take_any ? take_idx : '0;
                        result_next.running_thread  = take_any ? take_idx : '0;
                        result_next.registered_slot = '0;
                        result_next.table_full      = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            tok_start_reg <= 1'b0;
            done_reg      <= 1'b0;
            cur_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tok_start_reg <= tok_start_next;
            done_reg      <= done_next;
            cur_reg       <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            is_reg_reg <= (action_t'(item.action) == ACT_REGISTER);
            key_reg    <= item.name_key;
            now_reg    <= item.now_ms;
        end
    end

    assign busy   = (state_reg == FSM_SCAN);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a scan");

    a_accept_starts_token: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && tok_start_reg))
        else $error("accepted beat did not launch the scan token");

    a_reg_or_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.table_full && (result.registered_slot != '0)))
        else $error("slot written and table full on the same beat");

    a_stop_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stop_any |-> busy)
        else $error("slot cell stopped a scan while idle");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import tts_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int KEY_POOL_SIZE  = 24;
    localparam int BEATS_PER_PHASE = 212;

    typedef struct {
        tts_in_t beat;
        int      gap_pct;
        bit      drain;
    } sched_req_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    tts_in_t   item  = '0;
    logic      busy;
    logic      done;
    tts_out_t  result;

    sched_req_t   sched_req_q[$];
    tts_out_t     sched_exp_q[$];

    // scoreboard copy of the thread table
    slot_status_t      tbl_status[THREAD_SLOTS];
    logic [31:0]       tbl_key[THREAD_SLOTS];
    logic [31:0]       tbl_wake[THREAD_SLOTS];
    logic [SLOT_W-1:0] tbl_running;

    logic [31:0] key_pool[KEY_POOL_SIZE];

    int         err_cnt  = 0;
    int         idle_cyc = 0;
    logic       took;
    tts_out_t   next_exp;
    sched_req_t next_req;
    tts_out_t   want_beat;

    thread_table_scheduler DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    task automatic pick_next_thread(input logic [31:0] now);
        logic [SLOT_W-1:0] pick;
        pick = '0;
        for (int i = 1; i < THREAD_SLOTS; i++)
        begin
            if (tbl_status[i] == ST_EMPTY)
                break;
            if (tbl_status[i] == ST_SLEEP && $signed(tbl_wake[i]) < $signed(now))
                tbl_status[i] = ST_READY;
            if (tbl_status[i] == ST_READY)
            begin
                pick = i[SLOT_W-1:0];
                break;
            end
        end
        tbl_running = pick;
    endtask

    task automatic apply_sched_beat(input tts_in_t b, output tts_out_t r);
        int                i;
        logic [SLOT_W-1:0] cur;
        r                 = '0;
        r.previous_thread = tbl_running;
        cur               = tbl_running;
        case (action_t'(b.action))
            ACT_REGISTER:
            begin
                i = 1;
                while (i < THREAD_SLOTS && tbl_status[i] != ST_EMPTY && tbl_key[i] != b.name_key)
                    i++;
                if (i < THREAD_SLOTS)
                begin
                    tbl_key[i]        = b.name_key;
                    tbl_status[i]     = ST_READY;
                    r.registered_slot = i[SLOT_W-1:0];
                end
                else
                    r.table_full = 1'b1;
            end
            ACT_SLEEP:
            begin
                if (cur != 0 && tbl_status[cur] != ST_EMPTY)
                begin
                    tbl_status[cur] = ST_SLEEP;
                    tbl_wake[cur]   = b.now_ms + {1'b0, b.sleep_ms};
                end
                pick_next_thread(b.now_ms);
            end
            ACT_EXIT:
            begin
                if (cur != 0)
                    tbl_status[cur] = ST_EXIT;
                pick_next_thread(b.now_ms);
            end
            default:
                pick_next_thread(b.now_ms);
        endcase
        r.running_thread = tbl_running;
    endtask

    task automatic queue_beat(input action_t a, input logic [31:0] key, input logic [31:0] now,
                              input logic [30:0] ms, input int gap, input bit drain);
        sched_req_t req;
        req.beat.action   = a;
        req.beat.name_key = key;
        req.beat.now_ms   = now;
        req.beat.sleep_ms = ms;
        req.gap_pct       = gap;
        req.drain         = drain;
        sched_req_q.push_back(req);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("mismatch %s at %0t: expected %0d got %0d", fname, $realtime, want, got);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                apply_sched_beat(item, next_exp);
                sched_exp_q.push_back(next_exp);
            end
            if (start && !took)
                ;
            else if (sched_req_q.size() > 0
                     && !(sched_req_q[0].drain && sched_exp_q.size() != 0)
                     && $urandom_range(0, 99) >= sched_req_q[0].gap_pct)
            begin
                next_req = sched_req_q.pop_front();
                start    <= 1'b1;
                item     <= next_req.beat;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (sched_exp_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result beat at %0t", $realtime);
            end
            else
            begin
                want_beat = sched_exp_q.pop_front();
                check_field("running_thread", 32'(want_beat.running_thread),
                            32'(result.running_thread));
                check_field("previous_thread", 32'(want_beat.previous_thread),
                            32'(result.previous_thread));
                check_field("registered_slot", 32'(want_beat.registered_slot),
                            32'(result.registered_slot));
                check_field("table_full", 32'(want_beat.table_full),
                            32'(result.table_full));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int          gap;
        int          roll;
        logic [31:0] tick;
        logic [31:0] key;
        logic [30:0] ms;
        action_t     act;

        for (int i = 0; i < THREAD_SLOTS; i++)
        begin
            tbl_status[i] = ST_EMPTY;
            tbl_key[i]    = '0;
            tbl_wake[i]   = '0;
        end
        tbl_running = '0;

        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'h0000_0001;
        for (int i = 2; i < KEY_POOL_SIZE; i++)
        begin
            key_pool[i] = $urandom;
            if (key_pool[i] == 0)
                key_pool[i] = 32'h8000_0000;
        end

        // directed
        queue_beat(ACT_YIELD,    32'h1234_5678, 32'd0,        31'd0,          0, 1'b0);
        queue_beat(ACT_SLEEP,    32'h1,         32'd5,        31'h7FFF_FFFF,  0, 1'b0);
        queue_beat(ACT_EXIT,     32'h1,         32'd6,        31'd0,          0, 1'b0);
        queue_beat(ACT_REGISTER, key_pool[0],   32'd10,       31'd0,          0, 1'b0);
        queue_beat(ACT_REGISTER, key_pool[1],   32'd11,       31'd0,          0, 1'b0);
        queue_beat(ACT_REGISTER, key_pool[0],   32'd12,       31'd0,          0, 1'b0);
        queue_beat(ACT_YIELD,    32'h0,         32'd20,       31'd0,          0, 1'b0);
        queue_beat(ACT_SLEEP,    32'h0,         32'd100,      31'd50,         0, 1'b0);
        queue_beat(ACT_YIELD,    32'h0,         32'd150,      31'd0,          0, 1'b0);
        queue_beat(ACT_YIELD,    32'h0,         32'd151,      31'd0,          0, 1'b0);
        queue_beat(ACT_EXIT,     32'h0,         32'd160,      31'd0,          0, 1'b1);
        queue_beat(ACT_SLEEP,    32'h0,         32'h8000_0000, 31'h7FFF_FFFF, 0, 1'b0);
        queue_beat(ACT_YIELD,    32'h0,         32'h7FFF_FFFF, 31'd0,         0, 1'b0);
        queue_beat(ACT_REGISTER, key_pool[0],   32'd200,      31'd0,          0, 1'b0);
        queue_beat(ACT_YIELD,    32'h0,         32'd201,      31'd0,          0, 1'b0);
        queue_beat(ACT_SLEEP,    32'h0,         32'h7FFF_FFF0, 31'h20,        0, 1'b0);
        queue_beat(ACT_SLEEP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd0,         0, 1'b0);
        queue_beat(ACT_YIELD,    32'h0,         32'h0000_0000, 31'd0,         0, 1'b0);

        // random, in idling phases
        tick = 32'd1000;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                1:       gap = 87;
                3:       gap = 35;
                default: gap = 0;
            endcase
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 3)
                    tick = $urandom;
                else
                    tick = tick + $urandom_range(0, 40);
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    ms = 31'($urandom_range(0, 150));
                else if (roll < 95)
                    ms = 31'($urandom);
                else if (roll < 98)
                    ms = 31'h7FFF_FFFF;
                else
                    ms = '0;
                roll = $urandom_range(0, 99);
                if (roll < 25)
                    act = ACT_REGISTER;
                else if (roll < 55)
                    act = ACT_SLEEP;
                else if (roll < 65)
                    act = ACT_EXIT;
                else
                    act = ACT_YIELD;
                if (act == ACT_REGISTER && $urandom_range(0, 99) < 85)
                    key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
                else
                begin
                    key = $urandom;
                    if (key == 0)
                        key = 32'h1;
                end
                queue_beat(act, key, tick, ms, gap, n == 0 || $urandom_range(0, 99) < 2);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (sched_req_q.size() != 0 || start)
            @(posedge clk);
        while (sched_exp_q.size() != 0)
            @(posedge clk);
        repeat (THREAD_SLOTS + 4) @(posedge clk);

        if (sched_exp_q.size() != 0)
            err_cnt++;
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
